// ----- rtl/nms3d_pkg.sv -----
// Shared constants, payload types and control types of the 3D neighborhood maximum search.
`timescale 1ns / 1ps
package nms3d_pkg;

  // Axis index width and sample width of the voxel store
  localparam int AXIS_W    = 6;
  localparam int SAMPLE_W  = 16;
  localparam int MAX_REACH = 7;
  localparam int SIZE_W    = AXIS_W + 1;
  localparam int REACH_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = SIZE_W;
  localparam int ADDR_W    = 3 * AXIS_W;
  localparam int AXIS_SPAN = 1 << AXIS_W;

  // Item operation codes
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_X  = 3'd0,
    CFG_SIZE_Y  = 3'd1,
    CFG_SIZE_Z  = 3'd2,
    CFG_REACH_X = 3'd3,
    CFG_REACH_Y = 3'd4,
    CFG_REACH_Z = 3'd5
  } cfg_reg_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_CENTER,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // Input item
  typedef struct packed {
    logic                       op;
    logic [AXIS_W-1:0]          pos_x;
    logic [AXIS_W-1:0]          pos_y;
    logic [AXIS_W-1:0]          pos_z;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [AXIS_W-1:0]          best_x;
    logic [AXIS_W-1:0]          best_y;
    logic [AXIS_W-1:0]          best_z;
    logic signed [SAMPLE_W-1:0] best_value;
    logic                       center_bad;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic setup;
    logic rd_center;
    logic rd_scan;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bad;
    logic scan_last;
    logic out_busy;
  } sts_t;

endpackage

// ----- rtl/nms3d_ctrl.sv -----
// Controller state machine: sequences item intake, window scan and result hand-off.
`timescale 1ns / 1ps
module nms3d_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  output logic              in_ready_o,
  input  nms3d_pkg::sts_t   sts_i,
  output nms3d_pkg::cmd_t   cmd_o
);
  import nms3d_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        // loads complete on acceptance; a query starts a search
        in_ready_o = 1'b1;
        if (in_valid_i && (in_op_i == OP_QUERY)) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_CENTER;
      end
      ST_CENTER: begin
        if (sts_i.bad) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.rd_center = 1'b1;
          state_d         = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read word is compared here
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/nms3d_dp.sv -----
// Datapath: config registers, voxel memory, window counters, max compare and result register.
`timescale 1ns / 1ps
module nms3d_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_take_i,
  input  nms3d_pkg::in_item_t            in_data_i,
  input  logic                           cfg_valid_i,
  input  logic [nms3d_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [nms3d_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  nms3d_pkg::cmd_t                cmd_i,
  output nms3d_pkg::sts_t                sts_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output nms3d_pkg::out_item_t           out_data_o
);
  import nms3d_pkg::*;

  localparam int SUM_W = SIZE_W + 1;

  // Configuration registers
  logic [SIZE_W-1:0]  size_x_q, size_y_q, size_z_q;
  logic [REACH_W-1:0] reach_x_q, reach_y_q, reach_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q  <= SIZE_W'(AXIS_SPAN);
      size_y_q  <= SIZE_W'(AXIS_SPAN);
      size_z_q  <= SIZE_W'(AXIS_SPAN);
      reach_x_q <= REACH_W'(1);
      reach_y_q <= REACH_W'(1);
      reach_z_q <= REACH_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SIZE_X:  size_x_q  <= cfg_data_i;
        CFG_SIZE_Y:  size_y_q  <= cfg_data_i;
        CFG_SIZE_Z:  size_z_q  <= cfg_data_i;
        CFG_REACH_X: reach_x_q <= cfg_data_i[REACH_W-1:0];
        CFG_REACH_Y: reach_y_q <= cfg_data_i[REACH_W-1:0];
        CFG_REACH_Z: reach_z_q <= cfg_data_i[REACH_W-1:0];
        default: ;
      endcase
    end
  end

  // Query center, captured with every accepted item
  logic [AXIS_W-1:0] cen_x_q, cen_y_q, cen_z_q;

  always_ff @(posedge clk_i) begin
    if (in_take_i) begin
      cen_x_q <= in_data_i.pos_x;
      cen_y_q <= in_data_i.pos_y;
      cen_z_q <= in_data_i.pos_z;
    end
  end

  // Window bounds per axis: clamp reach and size, crop at the volume edge
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    eff_size = (s > SIZE_W'(AXIS_SPAN)) ? SIZE_W'(AXIS_SPAN) : s;
  endfunction

  function automatic logic [SUM_W-1:0] eff_reach(input logic [REACH_W-1:0] r);
    logic [SUM_W-1:0] rw;
    rw = SUM_W'(r);
    eff_reach = (rw > SUM_W'(MAX_REACH)) ? SUM_W'(MAX_REACH) : rw;
  endfunction

  function automatic logic [AXIS_W-1:0] lo_of(input logic [AXIS_W-1:0]  c,
                                              input logic [REACH_W-1:0] r);
    logic [SUM_W-1:0] cw, rw;
    cw = SUM_W'(c);
    rw = eff_reach(r);
    lo_of = (cw > rw) ? AXIS_W'(cw - rw) : '0;
  endfunction

  function automatic logic [AXIS_W-1:0] hi_of(input logic [AXIS_W-1:0]  c,
                                              input logic [REACH_W-1:0] r,
                                              input logic [SIZE_W-1:0]  n);
    logic [SUM_W-1:0] h, top;
    h   = SUM_W'(c) + eff_reach(r);
    top = SUM_W'(eff_size(n)) - SUM_W'(1);
    hi_of = (h > top) ? AXIS_W'(top) : AXIS_W'(h);
  endfunction

  logic [AXIS_W-1:0] lo_x_q, lo_y_q, lo_z_q;
  logic [AXIS_W-1:0] hi_x_q, hi_y_q, hi_z_q;
  logic              bad_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      lo_x_q <= lo_of(cen_x_q, reach_x_q);
      lo_y_q <= lo_of(cen_y_q, reach_y_q);
      lo_z_q <= lo_of(cen_z_q, reach_z_q);
      hi_x_q <= hi_of(cen_x_q, reach_x_q, size_x_q);
      hi_y_q <= hi_of(cen_y_q, reach_y_q, size_y_q);
      hi_z_q <= hi_of(cen_z_q, reach_z_q, size_z_q);
      bad_q  <= (SIZE_W'(cen_x_q) >= eff_size(size_x_q)) ||
                (SIZE_W'(cen_y_q) >= eff_size(size_y_q)) ||
                (SIZE_W'(cen_z_q) >= eff_size(size_z_q));
    end
  end

  // Raster counters, x fastest
  logic [AXIS_W-1:0] cnt_x_q, cnt_y_q, cnt_z_q;
  logic              end_x, end_y, end_z;

  assign end_x = (cnt_x_q == hi_x_q);
  assign end_y = (cnt_y_q == hi_y_q);
  assign end_z = (cnt_z_q == hi_z_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_center) begin
      cnt_x_q <= lo_x_q;
      cnt_y_q <= lo_y_q;
      cnt_z_q <= lo_z_q;
    end else if (cmd_i.rd_scan) begin
      if (!end_x) begin
        cnt_x_q <= cnt_x_q + AXIS_W'(1);
      end else begin
        cnt_x_q <= lo_x_q;
        if (!end_y) begin
          cnt_y_q <= cnt_y_q + AXIS_W'(1);
        end else begin
          cnt_y_q <= lo_y_q;
          cnt_z_q <= cnt_z_q + AXIS_W'(1);
        end
      end
    end
  end

  // Voxel memory: one write or one read per cycle, read data registered
  logic signed [SAMPLE_W-1:0] mem [2**ADDR_W];
  logic                       wr_en, rd_en;
  logic [ADDR_W-1:0]          wr_addr, rd_addr;
  logic [AXIS_W-1:0]          rd_x, rd_y, rd_z;
  logic signed [SAMPLE_W-1:0] rd_data_q;

  assign wr_en   = in_take_i && (in_data_i.op == OP_LOAD);
  assign wr_addr = {in_data_i.pos_z, in_data_i.pos_y, in_data_i.pos_x};
  assign rd_en   = cmd_i.rd_center || cmd_i.rd_scan;
  assign rd_x    = cmd_i.rd_center ? cen_x_q : cnt_x_q;
  assign rd_y    = cmd_i.rd_center ? cen_y_q : cnt_y_q;
  assign rd_z    = cmd_i.rd_center ? cen_z_q : cnt_z_q;
  assign rd_addr = {rd_z, rd_y, rd_x};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data_i.sample;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Tags that travel alongside the read word
  logic              rd_vld_q, rd_init_q;
  logic [AXIS_W-1:0] rd_x_q, rd_y_q, rd_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      rd_init_q <= 1'b0;
    end else begin
      rd_vld_q  <= rd_en;
      rd_init_q <= cmd_i.rd_center;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_x_q <= rd_x;
      rd_y_q <= rd_y;
      rd_z_q <= rd_z;
    end
  end

  // Running maximum: center seeds it, only strictly greater replaces
  logic signed [SAMPLE_W-1:0] best_q;
  logic [AXIS_W-1:0]          best_x_q, best_y_q, best_z_q;

  always_ff @(posedge clk_i) begin
    if (rd_vld_q && (rd_init_q || (rd_data_q > best_q))) begin
      best_q   <= rd_data_q;
      best_x_q <= rd_x_q;
      best_y_q <= rd_y_q;
      best_z_q <= rd_z_q;
    end
  end

  // Result register
  logic      out_valid_q;
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (bad_q) begin
        out_q.best_x     <= '0;
        out_q.best_y     <= '0;
        out_q.best_z     <= '0;
        out_q.best_value <= '0;
        out_q.center_bad <= 1'b1;
      end else begin
        out_q.best_x     <= best_x_q;
        out_q.best_y     <= best_y_q;
        out_q.best_z     <= best_z_q;
        out_q.best_value <= best_q;
        out_q.center_bad <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign sts_o.bad       = bad_q;
  assign sts_o.scan_last = end_x && end_y && end_z;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

endmodule

// ----- rtl/neighborhood_max_search_3d_top.sv -----
// Top level of the 3D neighborhood maximum search: controller plus datapath.
//
//  channel  signals                                  direction
//  in       in_valid_i / in_ready_o / in_data_i      load voxel or query center
//  out      out_valid_o / out_ready_i / out_data_o   one result per query
//  cfg      cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i   register writes
//
// A load item is written to the voxel memory as it is accepted.
// A query scans its window of up to 15*15*15 voxels, bound by the single
// memory port reading one voxel per cycle; a center outside the volume skips the scan.
// The result register holds a finished result while the next item is accepted; a
// stalled result holds the next query in its last cycle until the register frees.
// Reset clears control state and sets the registers to full size and reach 1; the
// voxel memory is not cleared.
`timescale 1ns / 1ps
module neighborhood_max_search_3d_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  nms3d_pkg::in_item_t              in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output nms3d_pkg::out_item_t             out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [nms3d_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [nms3d_pkg::CFG_DAT_W-1:0]  cfg_data_i
);
  import nms3d_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_take;

  assign in_take     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Sequencer
  nms3d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.op),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage, scan and compare
  nms3d_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_take_i   (in_take),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- bench/tb_neighborhood_max_search_3d_top.sv -----
// Self-checking testbench for the 3D neighborhood maximum search top level.
`timescale 1ns / 1ps
module tb_neighborhood_max_search_3d_top;
  import nms3d_pkg::*;

  localparam int STORE_DEPTH   = 1 << ADDR_W;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 16;
  // register indexes past the last real register, expected to be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // shadow copy of the register file
  logic [SIZE_W-1:0]  vol_size_x = 7'd64;
  logic [SIZE_W-1:0]  vol_size_y = 7'd64;
  logic [SIZE_W-1:0]  vol_size_z = 7'd64;
  logic [REACH_W-1:0] reach_x = 3'd1;
  logic [REACH_W-1:0] reach_y = 3'd1;
  logic [REACH_W-1:0] reach_z = 3'd1;

  // shadow voxel store and which entries hold a loaded value
  logic signed [SAMPLE_W-1:0] voxel_mem [STORE_DEPTH];
  bit                         voxel_loaded [STORE_DEPTH];

  out_item_t expected_peaks[$];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  neighborhood_max_search_3d_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] voxel_addr(int x, int y, int z);
    return ADDR_W'((z << (2 * AXIS_W)) | (y << AXIS_W) | x);
  endfunction

  function automatic int axis_span(logic [SIZE_W-1:0] s);
    return (int'(s) > AXIS_SPAN) ? AXIS_SPAN : int'(s);
  endfunction

  function automatic int axis_reach(logic [REACH_W-1:0] r);
    return (int'(r) > MAX_REACH) ? MAX_REACH : int'(r);
  endfunction

  // window along one axis, cropped at the volume bounds
  function automatic void crop_window(input int c, input int r, input int n,
                                      output int lo, output int hi);
    lo = (c > r) ? c - r : 0;
    hi = (c + r > n - 1) ? n - 1 : c + r;
  endfunction

  // expected result of one query against the shadow store
  function automatic out_item_t peak_of(in_item_t q);
    out_item_t                  res;
    int                         cx, cy, cz;
    int                         nx, ny, nz, lx, hx, ly, hy, lz, hz;
    logic signed [SAMPLE_W-1:0] best, v;
    res = '0;
    cx = int'(q.pos_x);
    cy = int'(q.pos_y);
    cz = int'(q.pos_z);
    nx = axis_span(vol_size_x);
    ny = axis_span(vol_size_y);
    nz = axis_span(vol_size_z);
    if (cx >= nx || cy >= ny || cz >= nz) begin
      res.center_bad = 1'b1;
      return res;
    end
    crop_window(cx, axis_reach(reach_x), nx, lx, hx);
    crop_window(cy, axis_reach(reach_y), ny, ly, hy);
    crop_window(cz, axis_reach(reach_z), nz, lz, hz);
    best = voxel_mem[voxel_addr(cx, cy, cz)];
    res.best_x = q.pos_x;
    res.best_y = q.pos_y;
    res.best_z = q.pos_z;
    // z, y, x raster; only a strictly greater value moves the peak
    for (int z = lz; z <= hz; z++) begin
      for (int y = ly; y <= hy; y++) begin
        for (int x = lx; x <= hx; x++) begin
          v = voxel_mem[voxel_addr(x, y, z)];
          if (v > best) begin
            best = v;
            res.best_x = AXIS_W'(x);
            res.best_y = AXIS_W'(y);
            res.best_z = AXIS_W'(z);
          end
        end
      end
    end
    res.best_value = best;
    return res;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    case (idx)
      CFG_SIZE_X:  vol_size_x = data;
      CFG_SIZE_Y:  vol_size_y = data;
      CFG_SIZE_Z:  vol_size_z = data;
      CFG_REACH_X: reach_x = data[REACH_W-1:0];
      CFG_REACH_Y: reach_y = data[REACH_W-1:0];
      CFG_REACH_Z: reach_z = data[REACH_W-1:0];
      default: ;
    endcase
  endfunction

  // extremes, a narrow band that forces ties, or anything
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: return SAMPLE_MIN;
          1: return SAMPLE_MAX;
          2: return '0;
          default: return -16'sd1;
        endcase
      end
      1: return SAMPLE_W'($urandom_range(3));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_peaks.size() == 0) begin
      flag_mismatch($sformatf("result %h with no query pending", got));
      return;
    end
    want = expected_peaks.pop_front();
    if (got.best_x !== want.best_x)
      flag_mismatch($sformatf("best_x got %0d want %0d", got.best_x, want.best_x));
    if (got.best_y !== want.best_y)
      flag_mismatch($sformatf("best_y got %0d want %0d", got.best_y, want.best_y));
    if (got.best_z !== want.best_z)
      flag_mismatch($sformatf("best_z got %0d want %0d", got.best_z, want.best_z));
    if (got.best_value !== want.best_value)
      flag_mismatch($sformatf("best_value got %0d want %0d", got.best_value,
                              want.best_value));
    if (got.center_bad !== want.center_bad)
      flag_mismatch($sformatf("center_bad got %0b want %0b", got.center_bad,
                              want.center_bad));
  endtask

  // result side: random stalls, check every accepted item
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: no completion within %0d cycles", CYCLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // valid is left high after acceptance; the next call or idle_block drops it
  task automatic send_item(input in_item_t item);
    logic [ADDR_W-1:0] a;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (item.op == OP_QUERY) begin
      expected_peaks.push_back(peak_of(item));
    end else begin
      a = voxel_addr(int'(item.pos_x), int'(item.pos_y), int'(item.pos_z));
      voxel_mem[a]    = item.sample;
      voxel_loaded[a] = 1'b1;
    end
  endtask

  task automatic load_voxel(input int x, input int y, input int z,
                            input logic signed [SAMPLE_W-1:0] val);
    in_item_t item;
    item.op     = OP_LOAD;
    item.pos_x  = AXIS_W'(x);
    item.pos_y  = AXIS_W'(y);
    item.pos_z  = AXIS_W'(z);
    item.sample = val;
    send_item(item);
  endtask

  // query a center, first loading any voxel of its window not yet written
  task automatic query_at(input int cx, input int cy, input int cz);
    in_item_t item;
    int       nx, ny, nz, lx, hx, ly, hy, lz, hz;
    nx = axis_span(vol_size_x);
    ny = axis_span(vol_size_y);
    nz = axis_span(vol_size_z);
    if (cx < nx && cy < ny && cz < nz) begin
      crop_window(cx, axis_reach(reach_x), nx, lx, hx);
      crop_window(cy, axis_reach(reach_y), ny, ly, hy);
      crop_window(cz, axis_reach(reach_z), nz, lz, hz);
      for (int z = lz; z <= hz; z++)
        for (int y = ly; y <= hy; y++)
          for (int x = lx; x <= hx; x++)
            if (!voxel_loaded[voxel_addr(x, y, z)]) load_voxel(x, y, z, pick_sample());
    end
    item.op     = OP_QUERY;
    item.pos_x  = AXIS_W'(cx);
    item.pos_y  = AXIS_W'(cy);
    item.pos_z  = AXIS_W'(cz);
    item.sample = SAMPLE_W'($urandom);
    send_item(item);
  endtask

  // drop valid, wait for every pending result, then let loads settle
  task automatic idle_block();
    in_valid <= 1'b0;
    while (expected_peaks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
  endtask

  task automatic set_volume(input logic [CFG_DAT_W-1:0] sx, input logic [CFG_DAT_W-1:0] sy,
                            input logic [CFG_DAT_W-1:0] sz, input logic [CFG_DAT_W-1:0] rx,
                            input logic [CFG_DAT_W-1:0] ry, input logic [CFG_DAT_W-1:0] rz);
    idle_block();
    write_reg(CFG_SIZE_X, sx);
    write_reg(CFG_SIZE_Y, sy);
    write_reg(CFG_SIZE_Z, sz);
    write_reg(CFG_REACH_X, rx);
    write_reg(CFG_REACH_Y, ry);
    write_reg(CFG_REACH_Z, rz);
    cfg_valid <= 1'b0;
  endtask

  // reset registers: corner windows, extremes and ties
  task automatic test_corner_windows();
    logic signed [SAMPLE_W-1:0] val;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // low corner: two maxima, the earlier one in raster order wins
    for (int z = 0; z <= 1; z++)
      for (int y = 0; y <= 1; y++)
        for (int x = 0; x <= 1; x++) begin
          val = SAMPLE_MIN;
          if (x + y + z == 0) val = '0;
          if ((x == 1 && y == 0 && z == 0) || (x == 0 && y == 1 && z == 0)) val = SAMPLE_MAX;
          load_voxel(x, y, z, val);
        end
    query_at(0, 0, 0);
    // high corner, all equal: the center is kept
    for (int z = 62; z <= 63; z++)
      for (int y = 62; y <= 63; y++)
        for (int x = 62; x <= 63; x++)
          load_voxel(x, y, z, SAMPLE_MIN);
    query_at(63, 63, 63);
    // center ties the window maximum
    load_voxel(0, 0, 0, SAMPLE_MAX);
    query_at(0, 0, 0);
  endtask

  // zero size, oversized sizes, wide reach data, spare indexes
  task automatic test_register_edges();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_volume(7'd0, 7'd64, 7'd64, 7'd1, 7'd1, 7'd1);
    query_at(0, 0, 0);
    query_at(63, 5, 5);
    set_volume(7'd127, 7'd100, 7'd65, 7'h78, 7'd0, 7'h09);
    idle_block();
    write_reg(CFG_SPARE_6, 7'd1);
    write_reg(CFG_SPARE_7, 7'd0);
    cfg_valid <= 1'b0;
    query_at(63, 0, 32);
    query_at(1, 63, 63);
  endtask

  // mostly window-filled queries over a small volume, with stray loads
  task automatic run_random_phase(input int steps, input int idle_pct, input int stall_pct,
                                  input int sx, input int sy, input int sz,
                                  input int rx, input int ry, input int rz);
    int nx, ny, nz, pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    set_volume(CFG_DAT_W'(sx), CFG_DAT_W'(sy), CFG_DAT_W'(sz),
               CFG_DAT_W'(rx), CFG_DAT_W'(ry), CFG_DAT_W'(rz));
    nx = axis_span(vol_size_x);
    ny = axis_span(vol_size_y);
    nz = axis_span(vol_size_z);
    repeat (steps) begin
      pick = $urandom_range(99);
      if (pick < 35)
        load_voxel($urandom_range(nx - 1), $urandom_range(ny - 1), $urandom_range(nz - 1),
                   pick_sample());
      else if (pick < 45)
        load_voxel($urandom_range(AXIS_SPAN - 1), $urandom_range(AXIS_SPAN - 1),
                   $urandom_range(AXIS_SPAN - 1), pick_sample());
      else if (pick < 90)
        query_at($urandom_range(nx - 1), $urandom_range(ny - 1), $urandom_range(nz - 1));
      else
        // center may fall past the volume
        query_at($urandom_range((nx + 2 > AXIS_SPAN - 1) ? AXIS_SPAN - 1 : nx + 2),
                 $urandom_range((ny + 2 > AXIS_SPAN - 1) ? AXIS_SPAN - 1 : ny + 2),
                 $urandom_range((nz + 2 > AXIS_SPAN - 1) ? AXIS_SPAN - 1 : nz + 2));
    end
  endtask

  // widest reach on every axis: full-width windows along x, cropping at both ends
  task automatic test_full_window();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_volume(7'd16, 7'd1, 7'd2, 7'd7, 7'd7, 7'd7);
    query_at(0, 0, 0);
    query_at(15, 0, 1);
    repeat (5) query_at($urandom_range(9, 6), 0, $urandom_range(1));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_windows();
    test_register_edges();
    run_random_phase(25, 0, 0, 3, 3, 3, 1, 1, 1);
    run_random_phase(15, 80, 0, 1, 1, 1, 0, 0, 0);
    run_random_phase(25, 0, 80, 4, 2, 3, 2, 0, 1);
    run_random_phase(20, 35, 35, 16, 1, 2, 7, 0, 1);
    run_random_phase(15, 80, 0, 2, 8, 1, 1, 7, 2);
    test_full_window();
    idle_block();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
